/* rtl/wsd_pkg.sv */
// Shared types and constants of the weight stream dequantizer.
package wsd_pkg;

    // Block layout of the signed byte format
    localparam int BLOCK_LEN = 32;
    localparam int POS_W     = $clog2(BLOCK_LEN + 3);

    // Item queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_FORMAT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLS   = 2'd2;

    // Weight formats
    localparam logic [1:0] FMT_SINGLE = 2'd0;
    localparam logic [1:0] FMT_HALF   = 2'd1;
    localparam logic [1:0] FMT_BLOCK  = 2'd2;

    // Single precision patterns
    localparam logic [31:0] SINGLE_INF = 32'h7f80_0000;
    localparam logic [31:0] QUIET_NAN  = 32'h7fc0_0000;
    localparam logic [31:0] QUIET_BIT  = 32'h0040_0000;

    // Work classes passed from the front to the back
    typedef enum logic [1:0] {
        OP_WORD,
        OP_HALF,
        OP_SCALE,
        OP_Q8
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [31:0] data;
        logic        last;
    } op_t;

endpackage

/* rtl/wsd_front.sv */
// Front part: byte assembly, format decoding and element counting.
module wsd_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [wsd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wsd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                           in_valid,
    input  logic [7:0]                     raw_byte,
    input  logic                           queue_full,
    output logic                           push,
    output wsd_pkg::op_t                   push_op
);
    import wsd_pkg::*;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_LEN + 1);

    logic [1:0]       fmt_reg, fmt_next;
    logic [15:0]      rows_reg, rows_next;
    logic [15:0]      cols_reg, cols_next;
    logic [31:0]      count_reg, count_next;
    logic [23:0]      gather_reg, gather_next;
    logic [1:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      done_reg, done_next;

    logic        accept;
    logic        restart;
    logic        emit;
    logic [31:0] done_inc;
    logic        last;

    // Decode one item and update the stream position
    always_comb
    begin
        fmt_next    = fmt_reg;
        rows_next   = rows_reg;
        cols_next   = cols_reg;
        count_next  = count_reg;
        gather_next = gather_reg;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        done_next   = done_reg;
        push        = 1'b0;
        push_op     = '{kind: OP_WORD, data: 32'd0, last: 1'b0};
        restart     = 1'b0;
        emit        = 1'b0;
        accept      = in_valid && !queue_full;
        done_inc    = done_reg + 32'd1;
        last        = (done_inc == count_reg);

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FORMAT:
                begin
                    fmt_next = cfg_wdata[1:0];
                    restart  = 1'b1;
                end
                CFG_ROWS:
                begin
                    rows_next  = cfg_wdata;
                    count_next = 32'(cfg_wdata) * 32'(cols_reg);
                    restart    = 1'b1;
                end
                CFG_COLS:
                begin
                    cols_next  = cfg_wdata;
                    count_next = 32'(rows_reg) * 32'(cfg_wdata);
                    restart    = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept && (count_reg != 32'd0))
        begin
            unique case (fmt_reg)
                FMT_SINGLE:
                begin
                    if (phase_reg != 2'd3)
                    begin
                        unique case (phase_reg)
                            2'd0:    gather_next[7:0]   = raw_byte;
                            2'd1:    gather_next[15:8]  = raw_byte;
                            default: gather_next[23:16] = raw_byte;
                        endcase
                        phase_next = phase_reg + 2'd1;
                    end
                    else
                    begin
                        push         = 1'b1;
                        push_op.kind = OP_WORD;
                        push_op.data = {raw_byte, gather_reg};
                        gather_next  = 24'd0;
                        phase_next   = 2'd0;
                        emit         = 1'b1;
                    end
                end
                FMT_HALF:
                begin
                    if (phase_reg == 2'd0)
                    begin
                        gather_next = {16'd0, raw_byte};
                        phase_next  = 2'd1;
                    end
                    else
                    begin
                        push         = 1'b1;
                        push_op.kind = OP_HALF;
                        push_op.data = {16'd0, raw_byte, gather_reg[7:0]};
                        gather_next  = 24'd0;
                        phase_next   = 2'd0;
                        emit         = 1'b1;
                    end
                end
                FMT_BLOCK:
                begin
                    if (pos_reg == POS_W'(0))
                    begin
                        gather_next = {16'd0, raw_byte};
                        pos_next    = POS_W'(1);
                    end
                    else if (pos_reg == POS_W'(1))
                    begin
                        push         = 1'b1;
                        push_op.kind = OP_SCALE;
                        push_op.data = {16'd0, raw_byte, gather_reg[7:0]};
                        gather_next  = 24'd0;
                        pos_next     = POS_W'(2);
                    end
                    else
                    begin
                        push         = 1'b1;
                        push_op.kind = OP_Q8;
                        push_op.data = {24'd0, raw_byte};
                        pos_next     = (pos_reg == POS_LAST) ? POS_W'(0) : pos_reg + POS_W'(1);
                        emit         = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // Count the element and close the tensor on the last one
            if (emit)
            begin
                push_op.last = last;
                done_next    = last ? 32'd0 : done_inc;
                if (last)
                begin
                    pos_next    = POS_W'(0);
                    phase_next  = 2'd0;
                    gather_next = 24'd0;
                end
            end
        end

        // Drop the stream position on any register write
        if (restart)
        begin
            gather_next = 24'd0;
            phase_next  = 2'd0;
            pos_next    = POS_W'(0);
            done_next   = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_SINGLE;
            rows_reg   <= 16'd0;
            cols_reg   <= 16'd0;
            count_reg  <= 32'd0;
            gather_reg <= 24'd0;
            phase_reg  <= 2'd0;
            pos_reg    <= POS_W'(0);
            done_reg   <= 32'd0;
        end
        else
        begin
            fmt_reg    <= fmt_next;
            rows_reg   <= rows_next;
            cols_reg   <= cols_next;
            count_reg  <= count_next;
            gather_reg <= gather_next;
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            done_reg   <= done_next;
        end
    end

endmodule

/* rtl/wsd_queue.sv */
// Short item queue between the front and back parts.
module wsd_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  wsd_pkg::op_t              push_op,
    input  logic                      pop,
    output logic                      nonempty,
    output logic                      full,
    output logic [wsd_pkg::QLVL_W-1:0] level,
    output wsd_pkg::op_t              head_op
);
    import wsd_pkg::*;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QLVL_W-1:0] level_reg, level_next;

    assign nonempty = (level_reg != QLVL_W'(0));
    assign full     = (level_reg == QLVL_W'(QUEUE_DEPTH));
    assign level    = level_reg;
    assign head_op  = entry_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? QPTR_W'(0) : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? QPTR_W'(0) : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            level_next = level_reg + QLVL_W'(1);
        end
        else if (pop && !push)
        begin
            level_next = level_reg - QLVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= QPTR_W'(0);
            rd_ptr_reg <= QPTR_W'(0);
            level_reg  <= QLVL_W'(0);
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Store the incoming item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* rtl/wsd_back.sv */
// Back part: half conversion, block step, product rounding and output register.
module wsd_back (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         op_valid,
    input  wsd_pkg::op_t op_in,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [31:0]  value_bits,
    output logic         end_of_tensor
);
    import wsd_pkg::*;

    // Exact half to single conversion
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic        s;
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  p;
        logic [22:0] frac;
        logic [31:0] r;
        s   = h[15];
        ex  = h[14:10];
        man = h[9:0];
        p   = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (man[i])
            begin
                p = 4'(i);
            end
        end
        frac = 23'({13'd0, man} << (5'd23 - {1'b0, p}));
        if (ex == 5'h1f)
        begin
            r = {s, 8'hff, man, 13'd0};
        end
        else if (ex == 5'd0)
        begin
            if (man == 10'd0)
            begin
                r = {s, 31'd0};
            end
            else
            begin
                r = {s, 8'(p) + 8'd103, frac};
            end
        end
        else
        begin
            r = {s, 8'(ex) + 8'd112, man, 13'd0};
        end
        return r;
    endfunction

    // Scale divided by 127, rounded to nearest even; the quotient digits of
    // r/127 repeat the seven bits of r, so no divider is needed
    function automatic logic [31:0] scale_step(input logic [31:0] x);
        logic [10:0] m;
        logic [3:0]  h;
        logic [6:0]  l;
        logic [7:0]  t;
        logic        carry;
        logic [6:0]  r;
        logic [4:0]  a;
        logic [32:0] q;
        logic [23:0] sig;
        logic        g;
        logic        st;
        logic [7:0]  ex;
        logic [30:0] mag;
        logic [31:0] res;
        m     = {1'b1, x[22:13]};
        h     = m[10:7];
        l     = m[6:0];
        t     = {4'd0, h} + {1'b0, l};
        carry = (t >= 8'd127);
        r     = carry ? 7'(t - 8'd127) : t[6:0];
        a     = {1'b0, h} + {4'd0, carry};
        q     = {a, r, r, r, r};
        if (a[4])
        begin
            sig = q[32:9];
            g   = q[8];
            st  = (|q[7:0]) | (r != 7'd0);
            ex  = x[30:23] - 8'd6;
        end
        else
        begin
            sig = q[31:8];
            g   = q[7];
            st  = (|q[6:0]) | (r != 7'd0);
            ex  = x[30:23] - 8'd7;
        end
        mag = {ex, sig[22:0]} + 31'(g & (st | sig[0]));
        if (x[30:0] > SINGLE_INF[30:0])
        begin
            res = x | QUIET_BIT;
        end
        else if ((x[30:23] == 8'hff) || (x[30:0] == 31'd0))
        begin
            res = x;
        end
        else
        begin
            res = {x[31], mag};
        end
        return res;
    endfunction

    logic adv;

    logic        s1_valid_reg, s1_valid_next;
    op_kind_t    s1_kind_reg;
    logic [31:0] s1_data_reg;
    logic        s1_last_reg;
    logic [31:0] s1_data_next;

    logic [31:0] step_reg, step_next;

    logic        s2_valid_reg, s2_valid_next;
    logic        s2_direct_reg, s2_direct_next;
    logic [31:0] s2_word_reg, s2_word_next;
    logic [31:0] s2_prod_reg, s2_prod_next;
    logic [7:0]  s2_exp_reg;
    logic        s2_sign_reg, s2_sign_next;
    logic        s2_last_reg;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] value_reg, value_next;
    logic        last_reg;

    logic [7:0]  byte_val;
    logic [7:0]  byte_mag;
    logic        st_nan;
    logic        st_inf;
    logic        st_zero;

    logic [4:0]  lead;
    logic [31:0] prod_norm;
    logic [7:0]  prod_exp;
    logic [30:0] prod_mag;

    // Move the whole pipeline unless a held result blocks the output
    assign adv           = !out_valid_reg || !out_stall;
    assign pop           = adv && op_valid;
    assign out_valid     = out_valid_reg;
    assign value_bits    = value_reg;
    assign end_of_tensor = last_reg;

    // Stage one: convert half words on entry
    always_comb
    begin
        s1_valid_next = op_valid;
        if ((op_in.kind == OP_HALF) || (op_in.kind == OP_SCALE))
        begin
            s1_data_next = half_to_single(op_in.data[15:0]);
        end
        else
        begin
            s1_data_next = op_in.data;
        end
    end

    // Stage two: take the block step, multiply and settle special operands
    always_comb
    begin
        byte_val       = s1_data_reg[7:0];
        byte_mag       = byte_val[7] ? 8'(~byte_val + 8'd1) : byte_val;
        st_nan         = (step_reg[30:0] > SINGLE_INF[30:0]);
        st_inf         = (step_reg[30:0] == SINGLE_INF[30:0]);
        st_zero        = (step_reg[30:0] == 31'd0);
        s2_sign_next   = step_reg[31] ^ byte_val[7];
        s2_prod_next   = {24'd0, byte_mag} * {8'd0, 1'b1, step_reg[22:0]};
        s2_valid_next  = s1_valid_reg && (s1_kind_reg != OP_SCALE);
        s2_direct_next = 1'b1;
        s2_word_next   = s1_data_reg;
        step_next      = step_reg;

        if (adv && s1_valid_reg && (s1_kind_reg == OP_SCALE))
        begin
            step_next = scale_step(s1_data_reg);
        end

        if (s1_kind_reg == OP_Q8)
        begin
            if (st_nan)
            begin
                s2_word_next = step_reg;
            end
            else if (st_inf && (byte_val == 8'd0))
            begin
                s2_word_next = QUIET_NAN;
            end
            else if (st_inf)
            begin
                s2_word_next = {s2_sign_next, SINGLE_INF[30:0]};
            end
            else if (st_zero || (byte_val == 8'd0))
            begin
                s2_word_next = {s2_sign_next, 31'd0};
            end
            else
            begin
                s2_direct_next = 1'b0;
            end
        end
    end

    // Stage three: normalise and round the product
    always_comb
    begin
        lead = 5'd23;
        for (int i = 23; i < 32; i++)
        begin
            if (s2_prod_reg[i])
            begin
                lead = 5'(i);
            end
        end
        prod_norm = s2_prod_reg << (5'd31 - lead);
        prod_exp  = s2_exp_reg + 8'(lead) - 8'd23;
        prod_mag  = {prod_exp, prod_norm[30:8]}
                  + 31'(prod_norm[7] & ((|prod_norm[6:0]) | prod_norm[8]));
        out_valid_next = s2_valid_reg;
        value_next     = s2_direct_reg ? s2_word_reg : {s2_sign_reg, prod_mag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= 32'd0;
        end
        else
        begin
            step_reg <= step_next;
            if (adv)
            begin
                s1_valid_reg  <= s1_valid_next;
                s2_valid_reg  <= s2_valid_next;
                out_valid_reg <= out_valid_next;
            end
        end
    end

    // Advance the payload of every stage together
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg   <= op_in.kind;
            s1_data_reg   <= s1_data_next;
            s1_last_reg   <= op_in.last;
            s2_direct_reg <= s2_direct_next;
            s2_word_reg   <= s2_word_next;
            s2_prod_reg   <= s2_prod_next;
            s2_exp_reg    <= step_reg[30:23];
            s2_sign_reg   <= s2_sign_next;
            s2_last_reg   <= s1_last_reg;
            value_reg     <= value_next;
            last_reg      <= s2_last_reg;
        end
    end

endmodule

/* rtl/weight_stream_dequantizer_unit.sv */
// Weight stream dequantizer: packed weight bytes in, single precision words out,
// one byte taken per clock with up to one word per clock, stalls on either side
// allowed. The byte that completes an element is written into the four-item queue
// at the edge that takes it and is popped from there into three pipeline stages
// (half conversion, block step and multiply, normalise and round) whenever the
// back part advances, which it does unless a held word is stalled at the output.
// The rate is set by the byte port: the multiply and rounding stages each handle
// one element per cycle while the output is not stalled. Register writes restart
// the stream and are meant to be made while no item is in flight.
module weight_stream_dequantizer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [wsd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wsd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     raw_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [31:0]                    value_bits,
    output logic                           end_of_tensor
);
    import wsd_pkg::*;

    logic              q_push;
    op_t               q_push_op;
    logic              q_pop;
    logic              q_nonempty;
    logic              q_full;
    logic [QLVL_W-1:0] q_level;
    op_t               q_head_op;

    // Hold off the byte port while the queue is full
    assign in_stall = q_full;

    wsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .raw_byte   (raw_byte),
        .queue_full (q_full),
        .push       (q_push),
        .push_op    (q_push_op)
    );

    wsd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_op  (q_push_op),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .full     (q_full),
        .level    (q_level),
        .head_op  (q_head_op)
    );

    wsd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .op_valid      (q_nonempty),
        .op_in         (q_head_op),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .value_bits    (value_bits),
        .end_of_tensor (end_of_tensor)
    );

    // The front never writes into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("item pushed into full queue");

    // The back never pops an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_nonempty)
        else $error("item popped from empty queue");

    // Fill level stays within the queue depth
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= QLVL_W'(QUEUE_DEPTH))
        else $error("queue level beyond depth");

    // A lone push raises the fill level by one
    a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> (q_level == $past(q_level) + QLVL_W'(1)))
        else $error("queue level did not follow push");

endmodule

/* bench/tb_scoreboard.sv */
// Dequantizer predictor and store of expected words for the weight stream bench.
`timescale 1ns / 1ps

class wsd_scoreboard;
    // Register copies
    logic [1:0]  fmt;
    logic [15:0] rows;
    logic [15:0] cols;

    // Stream state
    logic [23:0] gather;
    logic [1:0]  phase;
    int unsigned pos;
    logic [31:0] step;
    logic [31:0] done_cnt;

    // Expected words and their end flags, oldest first
    logic [31:0] exp_bits[$];
    logic        exp_last[$];
    int          errors;

    function new();
        fmt      = wsd_pkg::FMT_SINGLE;
        rows     = '0;
        cols     = '0;
        errors   = 0;
        restart();
    endfunction

    function void restart();
        gather   = '0;
        phase    = '0;
        pos      = 0;
        step     = '0;
        done_cnt = '0;
    endfunction

    function void set_reg(logic [wsd_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] val);
        if (idx == wsd_pkg::CFG_FORMAT)
            fmt = val[1:0];
        else if (idx == wsd_pkg::CFG_ROWS)
            rows = val;
        else if (idx == wsd_pkg::CFG_COLS)
            cols = val;
        else
            return;
        restart();
    endfunction

    function int pending();
        return exp_bits.size();
    endfunction

    // Round a double to the nearest single, ties to even, with subnormals
    function logic [31:0] round_single(real r);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        logic [31:0] res;
        int          e;
        int          se;
        int          sh;
        d = $realtobits(r);
        e = d[62:52];
        if (e == 2047)
            return (d[51:0] != 0) ? wsd_pkg::QUIET_NAN : {d[63], 31'h7f80_0000};
        if (e == 0)
            return {d[63], 31'b0};
        se  = e - 1023 + 127;
        sig = {11'b0, 1'b1, d[51:0]};
        sh  = (se >= 1) ? 29 : 29 + 1 - se;
        if (sh > 60)
            return {d[63], 31'b0};
        kept = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0]))
            kept = kept + 1;
        if (se >= 255)
            return {d[63], 31'h7f80_0000};
        if (se >= 1)
            res = 32'((se - 1) << 23) + kept[31:0];
        else
            res = kept[31:0];
        return {d[63], res[30:0]};
    endfunction

    function real single_real(logic [31:0] w);
        logic [10:0] ex;
        if (w[30:23] == 8'd0)
            return $bitstoreal({w[31], 63'b0});
        if (w[30:23] == 8'hff)
            return $bitstoreal({w[31], 11'h7ff, 52'b0});
        ex = 11'(w[30:23]) - 11'd127 + 11'd1023;
        return $bitstoreal({w[31], ex, w[22:0], 29'b0});
    endfunction

    function logic [31:0] half_single(logic [15:0] h);
        logic [31:0] mag;
        if (h[14:10] == 5'h1f)
            return {h[15], 8'hff, h[9:0], 13'b0};
        if (h[14:10] == 5'h00)
        begin
            if (h[9:0] == 10'd0)
                return {h[15], 31'b0};
            mag = round_single(real'(h[9:0]) * (2.0 ** -24));
            return {h[15], mag[30:0]};
        end
        return {h[15], 8'(h[14:10] + 8'd112), h[9:0], 13'b0};
    endfunction

    function logic [31:0] scale_step(logic [31:0] s);
        if (s[30:0] > 31'h7f80_0000)
            return s | wsd_pkg::QUIET_BIT;
        return round_single(single_real(s) / 127.0);
    endfunction

    function logic [31:0] q8_value(logic [31:0] st, logic [7:0] b);
        int sv;
        sv = int'(signed'(b));
        if (st[30:0] > 31'h7f80_0000)
            return st;
        if (st[30:0] == 31'h7f80_0000 && sv == 0)
            return wsd_pkg::QUIET_NAN;
        return round_single(real'(sv) * single_real(st));
    endfunction

    function void emit(logic [31:0] bits, logic [31:0] count);
        logic last;
        done_cnt = done_cnt + 1;
        last = (done_cnt >= count);
        if (last)
        begin
            done_cnt = '0;
            pos      = 0;
            phase    = '0;
            gather   = '0;
        end
        exp_bits.push_back(bits);
        exp_last.push_back(last);
    endfunction

    // Note an accepted byte; returns 1 when the block acts on it
    function bit note_byte(logic [7:0] b);
        logic [31:0] count;
        count = 32'(rows) * 32'(cols);
        if (count == 0 || fmt == 2'd3)
            return 0;
        if (fmt == wsd_pkg::FMT_SINGLE)
        begin
            if (phase < 3)
            begin
                gather = gather | (24'(b) << (8 * phase));
                phase  = phase + 1;
            end
            else
            begin
                emit({b, gather}, count);
                gather = '0;
                phase  = '0;
            end
        end
        else if (fmt == wsd_pkg::FMT_HALF)
        begin
            if (phase == 0)
            begin
                gather = 24'(b);
                phase  = 1;
            end
            else
            begin
                emit(half_single({b, gather[7:0]}), count);
                gather = '0;
                phase  = '0;
            end
        end
        else if (pos == 0)
        begin
            gather = 24'(b);
            pos    = 1;
        end
        else if (pos == 1)
        begin
            step   = scale_step(half_single({b, gather[7:0]}));
            gather = '0;
            pos    = 2;
        end
        else
        begin
            pos = pos + 1;
            if (pos >= wsd_pkg::BLOCK_LEN + 2)
                pos = 0;
            emit(q8_value(step, b), count);
        end
        return 1;
    endfunction

    function void check_result(logic [31:0] bits, logic last);
        logic [31:0] eb;
        logic        el;
        if (exp_bits.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected word %h last %b", bits, last);
            return;
        end
        eb = exp_bits.pop_front();
        el = exp_last.pop_front();
        if (bits !== eb || last !== el)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected %h last %b, got %h last %b", eb, el, bits, last);
        end
    endfunction
endclass

/* bench/tb_top.sv */
// Top-level bench of the weight stream dequantizer: stimulus, stalls and final verdict.
`timescale 1ns / 1ps

module tb_top;
    import wsd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             raw_byte;
    logic                   out_valid;
    logic                   out_stall;
    logic [31:0]            value_bits;
    logic                   end_of_tensor;

    wsd_scoreboard sb;
    int            bytes_used;
    int            burst_left;
    int            hold_left;
    int            stall_mode;
    int            mode_left;
    int            cycles;

    weight_stream_dequantizer_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .raw_byte     (raw_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value_bits   (value_bits),
        .end_of_tensor(end_of_tensor)
    );

    always #2 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Take words and stall on a pattern of shifting density, or hold off when asked
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(value_bits, end_of_tensor);
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 120);
            end
            mode_left--;
            out_stall <= ($urandom_range(0, 3) < stall_mode);
        end
    end

    // Drive one register write; the caller drops the write enable afterwards
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(logic [1:0] f, logic [15:0] r, logic [15:0] c);
        write_reg(CFG_FORMAT, {14'b0, f});
        write_reg(CFG_ROWS, r);
        write_reg(CFG_COLS, c);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one byte, hold it until taken, then maybe end the burst
    task automatic send_byte(logic [7:0] b);
        in_valid <= 1'b1;
        raw_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        if (sb.note_byte(b))
            bytes_used++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 48);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    task automatic send_half(logic [15:0] h);
        send_byte(h[7:0]);
        send_byte(h[15:8]);
    endtask

    task automatic send_word(logic [31:0] w);
        send_half(w[15:0]);
        send_half(w[31:16]);
    endtask

    // Wait until every expected word has come, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(0, 11))
            0:       return 16'h7c00 | 16'($urandom_range(0, 1) << 15);
            1:       return 16'h7c00 | 16'($urandom_range(1, 1023));
            2:       return 16'($urandom_range(0, 1) << 15);
            3:       return 16'($urandom_range(1, 1023));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // One random tensor phase with well-formed blocks in the signed byte format
    task automatic random_phase();
        logic [1:0]  f;
        logic [15:0] r;
        logic [15:0] c;
        logic [31:0] count;
        logic [15:0] sc;
        int          sel;
        int          nbytes;
        int          bpt;
        int          qpos;
        int          elem;
        sel = $urandom_range(0, 9);
        f   = (sel < 3) ? FMT_SINGLE : (sel < 6) ? FMT_HALF : FMT_BLOCK;
        r   = 16'($urandom_range(1, 3));
        c   = 16'($urandom_range(1, 70));
        if (sel == 9)
        begin
            f = ($urandom_range(0, 1) != 0) ? 2'd3 : FMT_HALF;
            r = (f == 2'd3) ? r : 16'd0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            r = 16'($urandom_range(1, 65535));
            c = 16'($urandom_range(1, 65535));
        end
        count = 32'(r) * 32'(c);
        if (f == FMT_SINGLE)
            bpt = 4 * count;
        else if (f == FMT_HALF)
            bpt = 2 * count;
        else
            bpt = count + 2 * ((count + BLOCK_LEN - 1) / BLOCK_LEN);
        nbytes = (count > 400) ? 60 : $urandom_range(1, 2) * bpt + $urandom_range(0, 3);
        if (nbytes > 320)
            nbytes = 320;
        configure(f, r, c);
        qpos = 0;
        elem = 0;
        for (int i = 0; i < nbytes; i++)
        begin
            if (f != FMT_BLOCK)
                send_byte(8'($urandom_range(0, 255)));
            else if (qpos == 0)
            begin
                sc = pick_scale();
                send_byte(sc[7:0]);
                qpos = 1;
            end
            else if (qpos == 1)
            begin
                send_byte(sc[15:8]);
                qpos = 2;
            end
            else
            begin
                send_byte(($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
                qpos++;
                elem++;
                if (qpos >= BLOCK_LEN + 2)
                    qpos = 0;
                if (elem == count)
                begin
                    elem = 0;
                    qpos = 0;
                end
            end
        end
        drain();
    endtask

    initial
    begin
        logic [15:0] halves[10];
        logic [15:0] scales[5];
        logic [7:0]  q8_bytes[10];
        halves   = '{16'h0000, 16'h8000, 16'h0001, 16'h83ff, 16'h0400,
                     16'h7bff, 16'h7c00, 16'hfc00, 16'h7c01, 16'hfe00};
        scales   = '{16'h7e01, 16'h7c00, 16'h0001, 16'hfbff, 16'h8000};
        q8_bytes = '{8'h05, 8'h80, 8'h00, 8'hfb, 8'h7f, 8'h80, 8'h80, 8'h7f, 8'h01, 8'hff};
        sb         = new();
        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        raw_byte   = '0;
        out_stall  = 1'b0;
        bytes_used = 0;
        burst_left = 8;
        hold_left  = 0;
        stall_mode = 0;
        mode_left  = 0;
        cycles     = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single words: all ones and all zeros
        configure(FMT_SINGLE, 16'd1, 16'd2);
        send_word(32'hffff_ffff);
        send_word(32'h0000_0000);
        drain();

        // Half extremes: zeros, subnormals, largest, infinities, NaN payloads
        configure(FMT_HALF, 16'd2, 16'd5);
        foreach (halves[i])
            send_half(halves[i]);
        drain();

        // Signed byte blocks: NaN, infinite, subnormal, largest and negative zero scales
        configure(FMT_BLOCK, 16'd1, 16'd2);
        foreach (scales[i])
        begin
            send_half(scales[i]);
            send_byte(q8_bytes[2 * i]);
            send_byte(q8_bytes[2 * i + 1]);
        end
        drain();

        // Ignored bytes: format three and empty tensors at the register extremes; a large half tensor takes them
        configure(2'd3, 16'd1, 16'd1);
        repeat (4) send_byte(8'($urandom_range(0, 255)));
        drain();
        configure(FMT_SINGLE, 16'hffff, 16'd0);
        repeat (4) send_byte(8'($urandom_range(0, 255)));
        drain();
        configure(FMT_SINGLE, 16'd0, 16'hffff);
        repeat (4) send_byte(8'($urandom_range(0, 255)));
        drain();
        configure(FMT_HALF, 16'd1, 16'hffff);
        repeat (8) send_byte(8'($urandom_range(0, 255)));
        drain();

        // Long receiver hold-off while bytes keep coming
        configure(FMT_HALF, 16'd3, 16'd40);
        hold_left = 200;
        repeat (240) send_byte(8'($urandom_range(0, 255)));
        drain();

        while (bytes_used < 1850)
            random_phase();

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
